// File: design/valve_hit_hold_controller_core_defines.svh
// Assertion macros for the checker file of the valve controller.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef VALVE_HIT_HOLD_CONTROLLER_CORE_DEFINES_SVH
`define VALVE_HIT_HOLD_CONTROLLER_CORE_DEFINES_SVH

// Overlapping implication: the consequent is checked at the same edge.
`define VHHC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Non-overlapping implication: the consequent starts at the next edge.
`define VHHC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/vhhc_pkg.sv
package vhhc_pkg;

    // Command codes carried in the cmd field of an input beat.
    localparam logic [2:0] CMD_OPEN  = 3'd0;
    localparam logic [2:0] CMD_CLOSE = 3'd1;
    localparam logic [2:0] CMD_SET   = 3'd2;
    localparam logic [2:0] CMD_TICK  = 3'd3;
    localparam logic [2:0] CMD_READ  = 3'd4;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] REG_HIT_TIME  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_HIT_DUTY  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_HOLD_DUTY = 2'd2;

    // Register reset values.
    localparam logic [15:0] HIT_TIME_RST  = 16'd500;
    localparam logic [6:0]  HIT_DUTY_RST  = 7'd100;
    localparam logic [6:0]  HOLD_DUTY_RST = 7'd50;

    // Results per tick are capped at this count.
    localparam int MAX_RESULTS = 16;

    typedef struct packed {
        logic [2:0]  cmd;
        logic        gang;
        logic [2:0]  valve;
        logic [31:0] now_ms;
    } in_item_t;

    typedef struct packed {
        logic [3:0] channel;
        logic [6:0] duty;
        logic       last;
    } out_item_t;

endpackage

// File: design/vhhc_ram.sv
module vhhc_ram #(
    parameter int WIDTH = 39,
    parameter int DEPTH = 16
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: design/valve_hit_hold_controller_core.sv
// Peak-and-hold controller for ganged solenoid valves.
//
// Commands arrive on the item port and are taken at a rising edge where start is
// high and busy is low. Open valve and close gang finish at that edge and never
// raise busy. Open set keeps busy high while it writes one opened valve per
// gang. A read keeps busy high for one cycle; its single result beat is shown
// in the next cycle.
//
// A tick walks the channel memory once, moving expired valves from hit to hold
// duty. If anything changed since the last report it then walks the first
// min(channels, 16) channels again and emits one beat per channel on consecutive
// cycles; the final one, marked by last, comes in the cycle after busy falls.
// The memory returns one word per cycle on its single read port.
//
// Results are shown for exactly one cycle with result_strobe; the receiver cannot
// stall them. Configuration beats are always ready; the user must send them only
// while idle, as the block does not enforce it. Reset marks every channel closed
// (duty 0, no open time) through per-entry valid bits, clears the report flag and
// restores the register defaults; no clearing pass.
module valve_hit_hold_controller_core #(
    parameter int GANGS           = 2,
    parameter int VALVES_PER_GANG = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  vhhc_pkg::in_item_t                  item,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [vhhc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [vhhc_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic                                result_strobe,
    output vhhc_pkg::out_item_t                 result
);

    localparam int NUM_CH = GANGS * VALVES_PER_GANG;
    localparam int AW     = (NUM_CH > 1) ? $clog2(NUM_CH) : 1;
    localparam int GW     = (GANGS > 1) ? $clog2(GANGS) : 1;
    localparam int NOUT   = (NUM_CH < vhhc_pkg::MAX_RESULTS) ? NUM_CH : vhhc_pkg::MAX_RESULTS;
    // The gang field is one bit and the valve field three bits wide.
    localparam int CH_MAX = VALVES_PER_GANG + 7;
    localparam int CHW    = $clog2(CH_MAX + 1);

    // One memory word holds a channel's duty and the time it was opened.
    typedef struct packed {
        logic [6:0]  duty;
        logic [31:0] open_time;
    } entry_t;

    localparam int EW = $bits(entry_t);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_OPEN  = 5'b00010,
        S_SCAN  = 5'b00100,
        S_EMIT  = 5'b01000,
        S_DRAIN = 5'b10000
    } state_t;

    typedef enum logic [1:0] {
        K_SCAN = 2'd0,
        K_EMIT = 2'd1,
        K_READ = 2'd2
    } kind_t;

    // Tracks a memory read whose data returns in the following cycle.
    typedef struct packed {
        logic          vld;
        kind_t         kind;
        logic [AW-1:0] addr;
        logic [3:0]    chan;
        logic          ok;
        logic          last;
    } pipe_t;

    state_t              state_reg, state_next;
    logic [GW-1:0]       gcnt_reg, gcnt_next;
    logic [AW-1:0]       ptr_reg, ptr_next;
    logic                pending_reg, pending_next;
    logic [NUM_CH-1:0]   valid_reg, valid_next;
    logic [15:0]         hit_time_reg, hit_time_next;
    logic [6:0]          hit_duty_reg, hit_duty_next;
    logic [6:0]          hold_duty_reg, hold_duty_next;
    pipe_t               pipe_reg, pipe_next;
    logic                result_strobe_reg, result_strobe_next;
    vhhc_pkg::out_item_t result_reg, result_next;
    logic [2:0]          valve_reg, valve_next;
    logic [31:0]         now_reg, now_next;

    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    entry_t              mem_wdata;
    logic [AW-1:0]       mem_raddr;
    logic [EW-1:0]       mem_rdata;
    entry_t              rd_entry;

    logic                accept;
    logic                gang_ok;
    logic                valve_ok;
    logic [CHW-1:0]      chan_calc;
    logic [AW-1:0]       item_addr;
    logic [AW-1:0]       set_addr;
    logic                hit;

    vhhc_ram #(
        .WIDTH (EW),
        .DEPTH (NUM_CH)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign rd_entry  = entry_t'(mem_rdata);
    assign accept    = start && (state_reg == S_IDLE);
    assign gang_ok   = int'(item.gang) < GANGS;
    assign valve_ok  = int'(item.valve) < VALVES_PER_GANG;
    assign chan_calc = CHW'(item.gang) * CHW'(VALVES_PER_GANG) + CHW'(item.valve);
    assign item_addr = AW'(chan_calc);
    assign set_addr  = AW'(int'(gcnt_reg) * VALVES_PER_GANG + int'(valve_reg));

    // A valve at hit duty with a nonzero open time whose elapsed time has reached
    // the hit time drops to hold duty.
    assign hit = pipe_reg.vld && (pipe_reg.kind == K_SCAN) && pipe_reg.ok &&
                 (rd_entry.open_time != 32'd0) &&
                 ((now_reg - rd_entry.open_time) >= {16'd0, hit_time_reg}) &&
                 (rd_entry.duty == hit_duty_reg);

    always_comb
    begin
        state_next         = state_reg;
        gcnt_next          = gcnt_reg;
        ptr_next           = ptr_reg;
        pending_next       = pending_reg;
        valid_next         = valid_reg;
        hit_time_next      = hit_time_reg;
        hit_duty_next      = hit_duty_reg;
        hold_duty_next     = hold_duty_reg;
        pipe_next          = '0;
        result_strobe_next = 1'b0;
        result_next        = result_reg;
        valve_next         = valve_reg;
        now_next           = now_reg;
        mem_we             = 1'b0;
        mem_waddr          = '0;
        mem_wdata          = '0;
        mem_raddr          = '0;

        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                vhhc_pkg::REG_HIT_TIME:  hit_time_next  = cfg_data;
                vhhc_pkg::REG_HIT_DUTY:  hit_duty_next  = cfg_data[6:0];
                vhhc_pkg::REG_HOLD_DUTY: hold_duty_next = cfg_data[6:0];
                default: ;
            endcase
        end

        // Data returning from the memory: write back expired valves during the
        // scan, or turn the word into a result beat for reports and reads.
        if (hit)
        begin
            mem_we       = 1'b1;
            mem_waddr    = pipe_reg.addr;
            mem_wdata    = '{duty: hold_duty_reg, open_time: rd_entry.open_time};
            pending_next = 1'b1;
        end
        if (pipe_reg.vld && (pipe_reg.kind != K_SCAN))
        begin
            result_strobe_next  = 1'b1;
            result_next.channel = pipe_reg.chan;
            result_next.duty    = pipe_reg.ok ? rd_entry.duty : 7'd0;
            result_next.last    = pipe_reg.last;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (item.cmd)
                        vhhc_pkg::CMD_OPEN:
                        begin
                            if (gang_ok && valve_ok)
                            begin
                                for (int j = 0; j < NUM_CH; j++)
                                begin
                                    if ((j / VALVES_PER_GANG) == int'(item.gang))
                                    begin
                                        valid_next[j] = 1'b0;
                                    end
                                end
                                valid_next[item_addr] = 1'b1;
                                mem_we       = 1'b1;
                                mem_waddr    = item_addr;
                                mem_wdata    = '{duty: hit_duty_reg, open_time: item.now_ms};
                                pending_next = 1'b1;
                            end
                        end
                        vhhc_pkg::CMD_CLOSE:
                        begin
                            if (gang_ok)
                            begin
                                for (int j = 0; j < NUM_CH; j++)
                                begin
                                    if ((j / VALVES_PER_GANG) == int'(item.gang))
                                    begin
                                        valid_next[j] = 1'b0;
                                    end
                                end
                                pending_next = 1'b1;
                            end
                        end
                        vhhc_pkg::CMD_SET:
                        begin
                            if (valve_ok)
                            begin
                                // Every gang is closed, then one valve per gang
                                // is written over the following cycles.
                                valid_next   = '0;
                                pending_next = 1'b1;
                                valve_next   = item.valve;
                                now_next     = item.now_ms;
                                gcnt_next    = '0;
                                state_next   = S_OPEN;
                            end
                        end
                        vhhc_pkg::CMD_TICK:
                        begin
                            now_next   = item.now_ms;
                            ptr_next   = '0;
                            state_next = S_SCAN;
                        end
                        vhhc_pkg::CMD_READ:
                        begin
                            mem_raddr      = item_addr;
                            pipe_next.vld  = 1'b1;
                            pipe_next.kind = K_READ;
                            pipe_next.addr = item_addr;
                            pipe_next.chan = 4'(chan_calc);
                            pipe_next.ok   = gang_ok && valve_ok && valid_reg[item_addr];
                            pipe_next.last = 1'b1;
                            state_next     = S_DRAIN;
                        end
                        default: ;
                    endcase
                end
            end
            S_OPEN:
            begin
                mem_we               = 1'b1;
                mem_waddr            = set_addr;
                mem_wdata            = '{duty: hit_duty_reg, open_time: now_reg};
                valid_next[set_addr] = 1'b1;
                if (gcnt_reg == GW'(GANGS - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    gcnt_next = gcnt_reg + 1'b1;
                end
            end
            S_SCAN:
            begin
                mem_raddr      = ptr_reg;
                pipe_next.vld  = 1'b1;
                pipe_next.kind = K_SCAN;
                pipe_next.addr = ptr_reg;
                pipe_next.chan = 4'(ptr_reg);
                pipe_next.ok   = valid_reg[ptr_reg];
                pipe_next.last = 1'b0;
                if (ptr_reg == AW'(NUM_CH - 1))
                begin
                    ptr_next   = '0;
                    state_next = S_DRAIN;
                end
                else
                begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end
            S_EMIT:
            begin
                mem_raddr      = ptr_reg;
                pipe_next.vld  = 1'b1;
                pipe_next.kind = K_EMIT;
                pipe_next.addr = ptr_reg;
                pipe_next.chan = 4'(ptr_reg);
                pipe_next.ok   = valid_reg[ptr_reg];
                pipe_next.last = (ptr_reg == AW'(NOUT - 1));
                if (ptr_reg == AW'(NOUT - 1))
                begin
                    ptr_next   = '0;
                    state_next = S_DRAIN;
                end
                else
                begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end
            S_DRAIN:
            begin
                // The last word of a scan is checked here; the report pass runs
                // only if something changed, and it consumes the pending flag.
                if ((pipe_reg.kind == K_SCAN) && (pending_reg || hit))
                begin
                    pending_next = 1'b0;
                    ptr_next     = '0;
                    state_next   = S_EMIT;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            gcnt_reg          <= '0;
            ptr_reg           <= '0;
            pending_reg       <= 1'b0;
            valid_reg         <= '0;
            hit_time_reg      <= vhhc_pkg::HIT_TIME_RST;
            hit_duty_reg      <= vhhc_pkg::HIT_DUTY_RST;
            hold_duty_reg     <= vhhc_pkg::HOLD_DUTY_RST;
            pipe_reg          <= '0;
            result_strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            gcnt_reg          <= gcnt_next;
            ptr_reg           <= ptr_next;
            pending_reg       <= pending_next;
            valid_reg         <= valid_next;
            hit_time_reg      <= hit_time_next;
            hit_duty_reg      <= hit_duty_next;
            hold_duty_reg     <= hold_duty_next;
            pipe_reg          <= pipe_next;
            result_strobe_reg <= result_strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        valve_reg  <= valve_next;
        now_reg    <= now_next;
    end

    assign busy          = (state_reg != S_IDLE);
    assign cfg_ready     = 1'b1;
    assign result_strobe = result_strobe_reg;
    assign result        = result_reg;

endmodule

// File: design/vhhc_checker.sv
`include "valve_hit_hold_controller_core_defines.svh"

module vhhc_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input vhhc_pkg::in_item_t  item,
    input logic                result_strobe,
    input vhhc_pkg::out_item_t result
);

    logic quick_cmd;
    logic read_cmd;

    assign quick_cmd = start && !busy &&
                       (item.cmd == vhhc_pkg::CMD_OPEN || item.cmd == vhhc_pkg::CMD_CLOSE);
    assign read_cmd  = start && !busy && (item.cmd == vhhc_pkg::CMD_READ);

    // Open valve and close gang complete at the command edge.
    `VHHC_ASSERT_NXT(a_quick_cmd_done, quick_cmd, !busy, "open or close raised busy")

    // A read raises busy and then answers with one final result beat.
    `VHHC_ASSERT_NXT(a_read_latency, read_cmd, busy ##1 (result_strobe && result.last), "read result missing")

    // Report beats run on consecutive cycles until the final one.
    `VHHC_ASSERT_NXT(a_report_burst, result_strobe && !result.last, result_strobe, "gap in report")

    // Results only appear while a command is in flight or just after it.
    `VHHC_ASSERT_IMP(a_result_in_cmd, result_strobe, busy || $past(busy), "stray result beat")

endmodule

bind valve_hit_hold_controller_core vhhc_checker u_checker (.*);
